[rtl/ffsqrt_pkg.sv]
// Package with the binary32 arithmetic and the pipeline stage schedule of the fast sqrt unit.
`timescale 1ns / 1ps

package ffsqrt_pkg;

  localparam int unsigned NumStages = 10;

  localparam logic [31:0] SeedMagic = 32'h5f3759df;
  localparam logic [31:0] FpHalf    = 32'h3F000000;
  localparam logic [31:0] FpThreeHalves = 32'h3FC00000;
  localparam logic [31:0] CanonNan  = 32'h7FC00000;

  typedef enum logic [2:0] {
    OP_HALF,
    OP_XY,
    OP_TY,
    OP_SUB,
    OP_YT,
    OP_FINAL
  } op_t;

  typedef struct packed {
    logic [31:0] num;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] t;
  } pipe_t;

  function automatic op_t stage_op(input int unsigned idx);
    op_t op;
    case (idx)
      0: op = OP_HALF;
      1, 5: op = OP_XY;
      2, 6: op = OP_TY;
      3, 7: op = OP_SUB;
      4, 8: op = OP_YT;
      default: op = OP_FINAL;
    endcase
    return op;
  endfunction

  // Binary32 multiply, round to nearest even, subnormals in and out.
  function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
    logic               s;
    logic [7:0]         ea;
    logic [7:0]         eb;
    logic [23:0]        ma;
    logic [23:0]        mb;
    logic [47:0]        pn;
    logic [5:0]         lz;
    logic signed [11:0] er;
    logic [11:0]        sh;
    logic               st;
    logic [7:0]         expf;
    logic               inc;
    logic [30:0]        mag;
    logic               a_nan;
    logic               b_nan;
    logic               a_inf;
    logic               b_inf;
    logic               a_zero;
    logic               b_zero;
    s      = a[31] ^ b[31];
    a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    a_zero = (a[30:0] == 31'd0);
    b_zero = (b[30:0] == 31'd0);
    ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    ma = {(a[30:23] != 8'd0), a[22:0]};
    mb = {(b[30:23] != 8'd0), b[22:0]};
    pn = ma * mb;
    lz = 6'd0;
    for (int i = 0; i < 48; i++) begin
      if (pn[i]) lz = 6'(47 - i);
    end
    pn = pn << lz;
    er = 12'(ea) + 12'(eb) - 12'sd126 - 12'(lz);
    st = 1'b0;
    expf = 8'd0;
    if (er < 12'sd1) begin
      sh = 12'(12'sd1 - er);
      if (sh >= 12'd48) begin
        st = |pn;
        pn = 48'd0;
      end else begin
        st = |(pn & ((48'd1 << sh) - 48'd1));
        pn = pn >> sh;
      end
    end else begin
      expf = er[7:0];
    end
    st  = st | (|pn[22:0]);
    inc = pn[23] & (st | pn[24]);
    mag = {expf, pn[46:24]} + {30'd0, inc};
    if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) begin
      return CanonNan;
    end else if (a_inf || b_inf) begin
      return {s, 8'hFF, 23'd0};
    end else if (a_zero || b_zero) begin
      return {s, 31'd0};
    end else if (er >= 12'sd255) begin
      return {s, 8'hFF, 23'd0};
    end
    return {s, mag};
  endfunction

  // Binary32 add, round to nearest even, subnormals in and out.
  function automatic logic [31:0] fadd(input logic [31:0] a, input logic [31:0] b);
    logic        a_nan;
    logic        b_nan;
    logic        a_inf;
    logic        b_inf;
    logic [31:0] lg;
    logic [31:0] sm;
    logic [7:0]  el;
    logic [7:0]  es;
    logic [7:0]  d;
    logic [26:0] ml;
    logic [26:0] msx;
    logic [26:0] small_m;
    logic [27:0] sum;
    logic [26:0] m27;
    logic [8:0]  e;
    logic [4:0]  lz;
    logic [8:0]  shl;
    logic [7:0]  expf;
    logic        inc;
    logic [30:0] mag;
    a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    a_inf = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    b_inf = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    if (a[30:0] >= b[30:0]) begin
      lg = a;
      sm = b;
    end else begin
      lg = b;
      sm = a;
    end
    el  = (lg[30:23] == 8'd0) ? 8'd1 : lg[30:23];
    es  = (sm[30:23] == 8'd0) ? 8'd1 : sm[30:23];
    d   = el - es;
    ml  = {(lg[30:23] != 8'd0), lg[22:0], 3'b000};
    msx = {(sm[30:23] != 8'd0), sm[22:0], 3'b000};
    if (d >= 8'd27) begin
      small_m = {26'd0, |msx};
    end else begin
      small_m = (msx >> d) | {26'd0, |(msx & ((27'd1 << d) - 27'd1))};
    end
    if (lg[31] == sm[31]) sum = {1'b0, ml} + {1'b0, small_m};
    else                  sum = {1'b0, ml} - {1'b0, small_m};
    e = {1'b0, el};
    if (sum[27]) begin
      m27 = {sum[27:2], sum[1] | sum[0]};
      e   = e + 9'd1;
    end else begin
      lz = 5'd0;
      for (int i = 0; i < 27; i++) begin
        if (sum[i]) lz = 5'(26 - i);
      end
      shl = ({4'd0, lz} < (e - 9'd1)) ? {4'd0, lz} : (e - 9'd1);
      m27 = sum[26:0] << shl;
      e   = e - shl;
    end
    expf = m27[26] ? e[7:0] : 8'd0;
    inc  = m27[2] & ((|m27[1:0]) | m27[3]);
    mag  = {expf, m27[25:3]} + {30'd0, inc};
    if (a_nan || b_nan || (a_inf && b_inf && (a[31] != b[31]))) begin
      return CanonNan;
    end else if (a_inf) begin
      return a;
    end else if (b_inf) begin
      return b;
    end else if (sum == 28'd0) begin
      return {a[31] & b[31], 31'd0};
    end else if (e >= 9'd255) begin
      return {lg[31], 8'hFF, 23'd0};
    end
    return {lg[31], mag};
  endfunction

  // One pipeline stage of the seed and Newton schedule.
  function automatic pipe_t stage_calc(input op_t op, input pipe_t d);
    pipe_t q;
    q = d;
    case (op)
      OP_HALF: begin
        q.x = fmul(d.num, FpHalf);
        q.y = SeedMagic - {d.num[31], d.num[31:1]};
        q.t = 32'd0;
      end
      OP_XY:    q.t = fmul(d.x, d.y);
      OP_TY:    q.t = fmul(d.t, d.y);
      OP_SUB:   q.t = fadd(FpThreeHalves, {~d.t[31], d.t[30:0]});
      OP_YT:    q.y = fmul(d.y, d.t);
      OP_FINAL: q.t = fmul(d.num, d.y);
      default:  q = d;
    endcase
    return q;
  endfunction

endpackage

[rtl/float_fast_sqrt_unit.sv]
// Top level of the pipelined binary32 fast approximate square root unit.
`timescale 1ns / 1ps

// Usage:
// An item enters on the s_axis channel as raw binary32 bits and leaves on
// the m_axis channel as the binary32 bits of its approximate square root.
// The root is number * y, where y is the magic-constant seed refined by two
// Newton steps, every float operation rounded to nearest even.
// Any NaN result comes out as the quiet NaN 0x7FC00000.
// An accepted item passes through the register stages in order and is offered
// on m_axis from the last one. The pipeline has ten register stages, one per
// float operation (one multiply or one add each; the first also forms the seed).
// Throughput is one item per cycle while the receiver does not stall.
// Reset clears all stage valid bits; the stage data is not reset.
// When the receiver stalls the whole pipeline holds, and s_axis_tready
// drops only while the last stage holds a result that is not taken.
module float_fast_sqrt_unit
  import ffsqrt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] operand_bits
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // [31:0] root_bits
);

  logic [NumStages-1:0] vld;
  pipe_t                stg      [NumStages];
  pipe_t                stg_next [NumStages];
  logic                 adv;

  assign adv = !vld[NumStages-1] || m_axis_tready;
  assign s_axis_tready = adv;

  genvar gi;
  generate
    for (gi = 0; gi < NumStages; gi++) begin : g_stage
      if (gi == 0) begin : g_first
        pipe_t din;
        always_comb begin
          din     = '0;
          din.num = s_axis_tdata;
        end
        assign stg_next[gi] = stage_calc(stage_op(gi), din);
        always_ff @(posedge clk) begin
          if (rst) begin
            vld[gi] <= 1'b0;
          end else if (adv) begin
            vld[gi] <= s_axis_tvalid;
          end
        end
      end else begin : g_rest
        assign stg_next[gi] = stage_calc(stage_op(gi), stg[gi-1]);
        always_ff @(posedge clk) begin
          if (rst) begin
            vld[gi] <= 1'b0;
          end else if (adv) begin
            vld[gi] <= vld[gi-1];
          end
        end
      end
      always_ff @(posedge clk) begin
        if (adv) begin
          stg[gi] <= stg_next[gi];
        end
      end
    end
  endgenerate

  assign m_axis_tvalid = vld[NumStages-1];
  assign m_axis_tdata  = stg[NumStages-1].t;

`ifndef NO_ASSERTIONS
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vld))
    else $error("stage valid bits moved during a stall");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> vld[0])
    else $error("accepted item missing from first stage");

  a_nan_canonical: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tdata[30:23] == 8'hFF) && (m_axis_tdata[22:0] != 23'd0))
      |-> (m_axis_tdata == CanonNan))
    else $error("non-canonical NaN on output");

  a_ready_rule: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow output stall");
`endif

endmodule

[sim/tb.sv]
// Self-checking testbench for the pipelined fast approximate square root unit.
`timescale 1ns / 1ps

module tb
  import ffsqrt_pkg::*;
;

  localparam int unsigned LatencyCycles = 10;
  localparam int unsigned StallLimit = 20000;
  localparam int unsigned RandomItems = 950;
  localparam int unsigned RecvHoldLen = 60;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;

  logic [31:0] operand_queue[$];
  logic [31:0] expected_roots[$];
  int unsigned mismatch_count = 0;
  int unsigned idle_cycles;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned recv_hold_cycles;
  int unsigned hold_req_count = 0;
  int unsigned hold_ack_count;
  bit          send_pause;
  logic        in_taken;

  float_fast_sqrt_unit dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit is_nan32(input logic [31:0] v);
    return (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
  endfunction

  // Binary32 multiply with round to nearest even and full subnormal support.
  function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
    logic              sgn;
    int                ea;
    int                eb;
    int                ex;
    logic [47:0]       prod;
    logic [23:0]       keep;
    logic              rnd;
    logic              sticky;
    logic [31:0]       res;
    int                msb;
    int                drop;
    sgn = a[31] ^ b[31];
    if (is_nan32(a) || is_nan32(b)) return CanonNan;
    if ((a[30:23] == 8'hFF && b[30:0] == 0) || (b[30:23] == 8'hFF && a[30:0] == 0))
      return CanonNan;
    if (a[30:23] == 8'hFF || b[30:23] == 8'hFF) return {sgn, 8'hFF, 23'd0};
    if (a[30:0] == 0 || b[30:0] == 0) return {sgn, 31'd0};
    ea = (a[30:23] == 0) ? 1 : a[30:23];
    eb = (b[30:23] == 0) ? 1 : b[30:23];
    prod = {a[30:23] != 0, a[22:0]} * {b[30:23] != 0, b[22:0]};
    msb = 0;
    for (int i = 0; i < 48; i++) if (prod[i]) msb = i;
    // Value is prod * 2^(ea+eb-300); biased exponent of the leading bit below.
    ex = ea + eb - 127 - 46 + msb;
    drop = msb - 23;
    if (ex < 1) drop = drop + (1 - ex);
    if (drop <= 0) begin
      keep = 24'(prod << (-drop));
      rnd = 1'b0;
      sticky = 1'b0;
    end else if (drop > 48) begin
      keep = 24'd0;
      rnd = 1'b0;
      sticky = 1'b1;
    end else begin
      keep = 24'(prod >> drop);
      rnd = prod[drop-1];
      sticky = (drop > 1) ? |(prod & ((48'd1 << (drop - 1)) - 48'd1)) : 1'b0;
    end
    if (ex < 1) ex = 0;
    // Adding the mantissa carry into the exponent handles overflow of rounding.
    res = {1'b0, 8'(ex == 0 ? 0 : ex - 1), 23'd0} + {8'd0, keep};
    if (rnd && (sticky || keep[0])) res = res + 32'd1;
    if (ex >= 255 || res[30:23] == 8'hFF) return {sgn, 8'hFF, 23'd0};
    return {sgn, res[30:0]};
  endfunction

  // Binary32 add with round to nearest even; magnitudes aligned on a wide grid.
  function automatic logic [31:0] add32(input logic [31:0] a, input logic [31:0] b);
    logic [31:0]       lg;
    logic [31:0]       sm;
    int                el;
    int                es;
    int                d;
    logic [60:0]       ml;
    logic [60:0]       ms;
    logic [60:0]       sum;
    logic              sticky;
    logic [31:0]       res;
    logic [23:0]       keep;
    logic              rnd;
    int                msb;
    int                ex;
    int                drop;
    if (is_nan32(a) || is_nan32(b)) return CanonNan;
    if (a[30:23] == 8'hFF && b[30:23] == 8'hFF && a[31] != b[31]) return CanonNan;
    if (a[30:23] == 8'hFF) return a;
    if (b[30:23] == 8'hFF) return b;
    if (a[30:0] >= b[30:0]) begin lg = a; sm = b; end
    else begin lg = b; sm = a; end
    el = (lg[30:23] == 0) ? 1 : lg[30:23];
    es = (sm[30:23] == 0) ? 1 : sm[30:23];
    d = el - es;
    ml = 61'({lg[30:23] != 0, lg[22:0]}) << 30;
    ms = 61'({sm[30:23] != 0, sm[22:0]}) << 30;
    sticky = 1'b0;
    if (d > 40) begin
      sticky = (ms != 0);
      ms = 61'd0;
    end else begin
      ms = ms >> d;
    end
    // The sticky bit sits below every kept bit, so it acts only as a tie breaker.
    if (lg[31] == sm[31]) sum = ml + ms;
    else sum = ml - ms - 61'(sticky);
    if (sum == 0 && !sticky) return {a[31] & b[31], 31'd0};
    msb = 0;
    for (int i = 0; i < 61; i++) if (sum[i]) msb = i;
    ex = el + msb - 53;
    drop = msb - 23;
    if (ex < 1) begin
      drop = drop + (1 - ex);
      ex = 0;
    end
    keep = 24'(sum >> drop);
    rnd = sum[drop-1];
    sticky = sticky | ((drop > 1) ? |(sum & ((61'd1 << (drop - 1)) - 61'd1)) : 1'b0);
    res = {1'b0, 8'(ex == 0 ? 0 : ex - 1), 23'd0} + {8'd0, keep};
    if (rnd && (sticky || keep[0])) res = res + 32'd1;
    if (ex >= 255 || res[30:23] == 8'hFF) return {lg[31], 8'hFF, 23'd0};
    return {lg[31], res[30:0]};
  endfunction

  function automatic logic [31:0] newton_refine(input logic [31:0] x, input logic [31:0] y);
    logic [31:0] t;
    t = mul32(mul32(x, y), y);
    t = add32(FpThreeHalves, {~t[31], t[30:0]});
    return mul32(y, t);
  endfunction

  function automatic logic [31:0] approx_root(input logic [31:0] operand);
    logic [31:0] half_x;
    logic [31:0] y;
    logic [31:0] r;
    half_x = mul32(operand, FpHalf);
    y = SeedMagic - {operand[31], operand[31:1]};
    y = newton_refine(half_x, y);
    y = newton_refine(half_x, y);
    r = mul32(operand, y);
    return is_nan32(r) ? CanonNan : r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at %0t: %s: root_bits got %h expected %h", $time, what, got, want);
    mismatch_count++;
  endtask

  // Driver: offers the next queued operand, idling at random.
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 32'd0;
    end else if (!s_axis_tvalid || in_taken) begin
      if (operand_queue.size() != 0 && !send_pause
          && $urandom_range(99) >= send_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= operand_queue[0];
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // On acceptance, records the expected root and pops the queue so the driver sees the next operand.
  always @(posedge clk) begin
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) begin
        expected_roots.push_back(approx_root(s_axis_tdata));
        void'(operand_queue.pop_front());
      end
    end
  end

  // Receiver: a hold request loads its own countdown of stalled cycles.
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready    <= 1'b0;
      recv_hold_cycles <= 0;
      hold_ack_count   <= 0;
    end else if (hold_ack_count != hold_req_count) begin
      hold_ack_count   <= hold_req_count;
      recv_hold_cycles <= RecvHoldLen;
      m_axis_tready    <= 1'b0;
    end else if (recv_hold_cycles != 0) begin
      recv_hold_cycles <= recv_hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor and watchdog.
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_roots.size() == 0) begin
          report_mismatch("unexpected result", m_axis_tdata, 32'd0);
        end else begin
          if (m_axis_tdata !== expected_roots[0])
            report_mismatch("wrong result", m_axis_tdata, expected_roots[0]);
          void'(expected_roots.pop_front());
        end
      end
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("** float_fast_sqrt_unit: FAILED **");
        $finish;
      end
    end
  end

  task automatic queue_random(input int unsigned count);
    logic [31:0] v;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(9))
        0: v = {1'($urandom_range(1)), 8'h00, 23'($urandom)};
        1: v = {1'($urandom_range(1)), 8'hFF, 23'($urandom_range(3))};
        2: v = {1'($urandom_range(1)), 8'($urandom_range(240, 254)), 23'($urandom)};
        3, 4: v = {1'b0, 8'($urandom_range(100, 160)), 23'($urandom)};
        default: v = $urandom;
      endcase
      operand_queue.push_back(v);
    end
  endtask

  initial begin
    rst = 1'b1;
    send_pause = 1'b0;
    send_idle_pct = 11;
    recv_idle_pct = 69;
    // Zeros, infinities, NaNs, subnormals, extremes, negatives and ordinary squares.
    operand_queue = '{32'h00000000, 32'h80000000, 32'h7F800000, 32'hFF800000,
                      32'h7FC00000, 32'hFFFFFFFF, 32'h7F800001, 32'h00000001,
                      32'h007FFFFF, 32'h80000001, 32'h00800000, 32'h7F7FFFFF,
                      32'hFF7FFFFF, 32'h3F800000, 32'h40800000, 32'h41100000,
                      32'hBF800000, 32'h3E800000, 32'h5F3759DF, 32'hAAAAAAAA,
                      32'h55555555, 32'h4B800000};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    queue_random(RandomItems / 3);
    wait (operand_queue.size() == 0);
    // Long receiver hold while the sender keeps offering items.
    hold_req_count = hold_req_count + 1;
    send_idle_pct = 0;
    queue_random(40);
    wait (operand_queue.size() == 0);
    // Sender pause until the pipeline has drained.
    send_pause = 1'b1;
    wait (expected_roots.size() == 0);
    send_pause = 1'b0;
    send_idle_pct = 69;
    recv_idle_pct = 11;
    queue_random(RandomItems / 3);
    wait (operand_queue.size() == 0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(RandomItems / 3);
    wait (operand_queue.size() == 0);
    wait (expected_roots.size() == 0);
    repeat (LatencyCycles + 5) @(posedge clk);
    if (mismatch_count == 0 && expected_roots.size() == 0)
      $display("** float_fast_sqrt_unit: PASSED **");
    else
      $display("** float_fast_sqrt_unit: FAILED **");
    $finish;
  end

endmodule

[filelist.f]
rtl/ffsqrt_pkg.sv
rtl/float_fast_sqrt_unit.sv
sim/tb.sv
